[hw/rtl/iois_pkg.sv]
// shared types and constants for the insertion-ordered index set
package iois_pkg;

  localparam int ELEM_W   = 6;
  localparam int DEPTH    = 2 ** ELEM_W;
  localparam int UNIVERSE = 64;
  localparam int CNT_W    = 7;
  localparam int OPC_W    = 2;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W   = OPC_W + ELEM_W;
  localparam int OUT_FIELDS_W = STATUS_W + 1 + CNT_W + ELEM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_LIST   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 3'd0,
    STAT_PRESENT = 3'd1,
    STAT_ABSENT  = 3'd2,
    STAT_LIST    = 3'd3,
    STAT_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_LIST
  } state_t;

  // requested access to the two link memories, driven combinationally each cycle
  typedef struct packed {
    logic              next_we;
    logic [ELEM_W-1:0] next_waddr;
    logic [ELEM_W-1:0] next_wdata;
    logic              prev_we;
    logic [ELEM_W-1:0] prev_waddr;
    logic [ELEM_W-1:0] prev_wdata;
    logic              next_re;
    logic              prev_re;
    logic [ELEM_W-1:0] raddr;
  } link_req_t;

endpackage

[hw/rtl/iois_link_ram.sv]
// generic single-write single-read ram with registered read data
module iois_link_ram #(
  parameter int AW = 6,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/iois_ctrl.sv]
// sequencer: membership bits, head/tail/count and link memory updates
module iois_ctrl import iois_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  output link_req_t              link_req,
  input  logic [ELEM_W-1:0]      next_rdata,
  input  logic [ELEM_W-1:0]      prev_rdata
);

  state_t            state, state_next;
  logic [DEPTH-1:0]  present, present_next;
  logic [ELEM_W-1:0] head, head_next;
  logic [ELEM_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ELEM_W-1:0] del_elem, del_elem_next;
  logic [ELEM_W-1:0] cur, cur_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              use_ram, use_ram_next;

  logic              out_valid, out_valid_next;
  status_t           out_status, out_status_next;
  logic              out_member, out_member_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic [ELEM_W-1:0] out_value, out_value_next;
  logic              out_last, out_last_next;

  opcode_t           op;
  logic [ELEM_W-1:0] elem;
  logic              in_range;
  logic              member;
  logic              out_free;
  logic              accept;
  logic [ELEM_W-1:0] cur_eff;

  assign op       = opcode_t'(s_tdata[OPC_W-1:0]);
  assign elem     = s_tdata[OPC_W +: ELEM_W];
  assign in_range = ({1'b0, elem} < CNT_W'(UNIVERSE));
  assign member   = in_range && present[elem];
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  // after the first list item the walk follows the link just read
  assign cur_eff  = use_ram ? next_rdata : cur;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_DELETE && member) begin
            state_next = S_DEL;
          end else if (op == OP_LIST && count != '0) begin
            state_next = S_LIST;
          end
        end
      end
      S_DEL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && remain == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    present_next    = present;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    del_elem_next   = del_elem;
    cur_next        = cur;
    remain_next     = remain;
    use_ram_next    = use_ram;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_member_next = out_member;
    out_count_next  = out_count;
    out_value_next  = out_value;
    out_last_next   = out_last;
    link_req        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT: begin
              out_valid_next  = 1'b1;
              out_value_next  = '0;
              out_last_next   = 1'b1;
              out_count_next  = count;
              if (!in_range) begin
                out_status_next = STAT_ABSENT;
                out_member_next = 1'b0;
              end else if (member) begin
                out_status_next = STAT_PRESENT;
                out_member_next = 1'b1;
              end else begin
                if (count == '0) begin
                  head_next = elem;
                end else begin
                  link_req.next_we    = 1'b1;
                  link_req.next_waddr = tail;
                  link_req.next_wdata = elem;
                  link_req.prev_we    = 1'b1;
                  link_req.prev_waddr = elem;
                  link_req.prev_wdata = tail;
                end
                tail_next           = elem;
                present_next[elem]  = 1'b1;
                count_next          = count + 1'b1;
                out_status_next     = STAT_DONE;
                out_member_next     = 1'b1;
                out_count_next      = count + 1'b1;
              end
            end
            OP_DELETE: begin
              if (member) begin
                link_req.next_re = 1'b1;
                link_req.prev_re = 1'b1;
                link_req.raddr   = elem;
                del_elem_next    = elem;
              end else begin
                out_valid_next  = 1'b1;
                out_status_next = STAT_ABSENT;
                out_member_next = 1'b0;
                out_count_next  = count;
                out_value_next  = '0;
                out_last_next   = 1'b1;
              end
            end
            OP_QUERY: begin
              out_valid_next  = 1'b1;
              out_status_next = STAT_DONE;
              out_member_next = member;
              out_count_next  = count;
              out_value_next  = '0;
              out_last_next   = 1'b1;
            end
            OP_LIST: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = STAT_EMPTY;
                out_member_next = 1'b0;
                out_count_next  = count;
                out_value_next  = '0;
                out_last_next   = 1'b1;
              end else begin
                cur_next     = head;
                remain_next  = count;
                use_ram_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL: begin
        if (out_free) begin
          // unlink: prev_rdata and next_rdata hold the neighbors
          if (head == del_elem) begin
            head_next = next_rdata;
          end else begin
            link_req.next_we    = 1'b1;
            link_req.next_waddr = prev_rdata;
            link_req.next_wdata = next_rdata;
          end
          if (tail == del_elem) begin
            tail_next = prev_rdata;
          end else begin
            link_req.prev_we    = 1'b1;
            link_req.prev_waddr = next_rdata;
            link_req.prev_wdata = prev_rdata;
          end
          present_next[del_elem] = 1'b0;
          count_next             = count - 1'b1;
          out_valid_next         = 1'b1;
          out_status_next        = STAT_DONE;
          out_member_next        = 1'b0;
          out_count_next         = count - 1'b1;
          out_value_next         = '0;
          out_last_next          = 1'b1;
        end
      end
      S_LIST: begin
        if (out_free) begin
          link_req.next_re = 1'b1;
          link_req.raddr   = cur_eff;
          use_ram_next     = 1'b1;
          remain_next      = remain - 1'b1;
          out_valid_next   = 1'b1;
          out_status_next  = STAT_LIST;
          out_member_next  = 1'b1;
          out_count_next   = count;
          out_value_next   = cur_eff;
          out_last_next    = (remain == CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      present   <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      use_ram   <= 1'b0;
      remain    <= '0;
    end else begin
      state     <= state_next;
      present   <= present_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      use_ram   <= use_ram_next;
      remain    <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    del_elem   <= del_elem_next;
    cur        <= cur_next;
    out_status <= out_status_next;
    out_member <= out_member_next;
    out_count  <= out_count_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                     out_value, out_count, out_member, out_status};

endmodule

[hw/rtl/insertion_ordered_index_set_core.sv]
// insertion-ordered index set: two link memories and the update sequencer
// insert, query, rejected items and empty list give their result in the cycle after the
// request; delete reads the links first, then writes the unlink and its result in S_DEL.
// throughput: one request per cycle when the output is not stalled; delete and list take
// no new request until done, list giving one member per unstalled cycle as the next-link
// memory read is chained to the walk. reset: membership bits, head, tail and count clear;
// link memories keep their contents and need no clearing pass
module insertion_ordered_index_set_core import iois_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode, element
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // status, is_member, member_count, listed_value
  output logic                   m_tlast
);

  link_req_t         link_req;
  logic [ELEM_W-1:0] next_rdata;
  logic [ELEM_W-1:0] prev_rdata;

  iois_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .link_req   (link_req),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata)
  );

  iois_link_ram #(.AW(ELEM_W), .DW(ELEM_W)) u_next_ram (
    .clk   (clk),
    .we    (link_req.next_we),
    .waddr (link_req.next_waddr),
    .wdata (link_req.next_wdata),
    .re    (link_req.next_re),
    .raddr (link_req.raddr),
    .rdata (next_rdata)
  );

  iois_link_ram #(.AW(ELEM_W), .DW(ELEM_W)) u_prev_ram (
    .clk   (clk),
    .we    (link_req.prev_we),
    .waddr (link_req.prev_waddr),
    .wdata (link_req.prev_wdata),
    .re    (link_req.prev_re),
    .raddr (link_req.raddr),
    .rdata (prev_rdata)
  );

endmodule

[hw/rtl/iois_checker.sv]
// port-level checks for the insertion-ordered index set
module iois_checker import iois_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast
);

  logic [STATUS_W-1:0] stat;
  logic                mbr;
  logic [CNT_W-1:0]    cnt;
  logic [ELEM_W-1:0]   val;

  assign stat = m_tdata[STATUS_W-1:0];
  assign mbr  = m_tdata[STATUS_W];
  assign cnt  = m_tdata[STATUS_W+1 +: CNT_W];
  assign val  = m_tdata[STATUS_W+1+CNT_W +: ELEM_W];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // only list items may leave the request unfinished
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat != STAT_LIST |-> m_tlast && val == '0)
    else $error("non-list result not final or carries a value");

  // a list item is a member of a nonempty set
  a_list_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat == STAT_LIST |-> mbr && cnt != '0)
    else $error("list item inconsistent");

  // no new request while a walk is still going
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat == STAT_LIST && !m_tlast |-> !s_tready)
    else $error("request taken during list walk");

  // the element count never exceeds the set size limit
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt <= CNT_W'(UNIVERSE))
    else $error("member count out of range");

endmodule

bind insertion_ordered_index_set_core iois_checker u_iois_checker (.*);
